[rtl/bmc_pkg.sv]
// Package for the sample bit mask crusher.
// Holds the sample widths, the register index codes, the configuration struct
// and the struct that travels along the cube root cell chain. No dependencies.
package bmc_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int FRAC_BITS   = SAMPLE_BITS - 1;
    localparam int OUT_BITS    = SAMPLE_BITS + 1;
    localparam int QUANT_BITS  = 15;
    localparam int RAD_W       = 3 * SAMPLE_BITS;
    localparam int SQ_W        = 2 * SAMPLE_BITS;
    localparam int REM_W       = SQ_W + 4;
    localparam int PROD_W      = SAMPLE_BITS + QUANT_BITS;
    localparam int DIV_W       = FRAC_BITS + 2;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = QUANT_BITS;

    localparam logic [QUANT_BITS-1:0] QUANT_MAX = {QUANT_BITS{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BIT_MASK     = CFG_IDX_W'(0),
        REG_XOR_ENABLE   = CFG_IDX_W'(1),
        REG_AND_ENABLE   = CFG_IDX_W'(2),
        REG_POWER_ENABLE = CFG_IDX_W'(3)
    } t_cfg_reg;

    typedef struct packed {
        logic [QUANT_BITS-1:0] bit_mask;
        logic                  xor_en;
        logic                  and_en;
        logic                  power_en;
    } t_cfg;

    typedef struct packed {
        logic                   valid;
        logic                   neg;
        logic [SAMPLE_BITS-1:0] mag;
        logic [RAD_W-1:0]       rad;
        logic [SAMPLE_BITS-1:0] y;
        logic [SQ_W-1:0]        s;
        logic [REM_W-1:0]       rem;
    } t_cell;

endpackage

[rtl/bmc_if.sv]
// Handshake channels of the sample bit mask crusher: sample in, sample out
// and the configuration write channel. Depends on bmc_pkg.
interface bmc_in_if import bmc_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] in_sample;

    modport source (output valid, output in_sample, input ready);
    modport sink (input valid, input in_sample, output ready);
endinterface

interface bmc_out_if import bmc_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] out_sample;

    modport source (output valid, output out_sample, input ready);
    modport sink (input valid, input out_sample, output ready);
endinterface

interface bmc_cfg_if import bmc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/bmc_root_cell.sv]
// One cell of the cube root chain: settles one root bit from three radicand bits per
// cycle while enabled, carrying root, root squared and remainder. Depends on bmc_pkg.
module bmc_root_cell import bmc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_cell i_cell,
    output t_cell o_cell
);

    logic [SAMPLE_BITS-1:0] w_y2;
    logic [SQ_W-1:0]        w_s4;
    logic [REM_W-1:0]       w_rem8;
    logic [REM_W-1:0]       w_b;
    logic                   w_take;
    t_cell                  r_cell;
    t_cell                  n_cell;

    assign w_y2   = {i_cell.y[SAMPLE_BITS-2:0], 1'b0};
    assign w_s4   = {i_cell.s[SQ_W-3:0], 2'b00};
    assign w_rem8 = {i_cell.rem[REM_W-4:0], i_cell.rad[RAD_W-1 -: 3]};
    // Trial term 3*(2y)^2 + 3*(2y) + 1, with the square carried from the last cell.
    assign w_b    = (REM_W'(w_s4) << 1) + REM_W'(w_s4)
                  + (REM_W'(w_y2) << 1) + REM_W'(w_y2) + REM_W'(1);
    assign w_take = (w_rem8 >= w_b);

    always_comb begin
        n_cell       = i_cell;
        n_cell.rad   = i_cell.rad << 3;
        n_cell.y     = w_y2 | SAMPLE_BITS'(w_take);
        n_cell.s     = w_take ? (w_s4 + (SQ_W'(w_y2) << 1) + SQ_W'(1)) : w_s4;
        n_cell.rem   = w_take ? (w_rem8 - w_b) : w_rem8;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

[rtl/bmc_root_chain.sv]
// Sign split and magnitude register followed by the row of cube root
// cells, one per root bit. Depends on bmc_pkg and bmc_root_cell.
module bmc_root_chain import bmc_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output t_cell                  o_cell
);

    t_cell r_head;
    t_cell n_head;
    t_cell w_link [SAMPLE_BITS+1];

    // The most negative sample gives a magnitude of exactly one.
    always_comb begin
        n_head       = '0;
        n_head.valid = i_valid;
        n_head.neg   = i_sample[FRAC_BITS];
        n_head.mag   = i_sample[FRAC_BITS] ? (~i_sample + SAMPLE_BITS'(1)) : i_sample;
        n_head.rad   = RAD_W'(n_head.mag) << (2 * FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head.valid <= 1'b0;
        end else if (i_en) begin
            r_head <= n_head;
        end
    end

    assign w_link[0] = r_head;

    for (genvar g = 0; g < SAMPLE_BITS; g++) begin : g_cell
        bmc_root_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (i_en),
            .i_cell (w_link[g]),
            .o_cell (w_link[g+1])
        );
    end

    assign o_cell = w_link[SAMPLE_BITS];

endmodule

[rtl/bmc_post.sv]
// Back end of the crusher: quantize and mask, rescale, optional cube and sign
// restore, in five registered stages. Depends on bmc_pkg.
module bmc_post import bmc_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  t_cfg                       i_cfg,
    input  t_cell                      i_cell,
    output logic                       o_valid,
    output logic signed [OUT_BITS-1:0] o_sample
);

    logic [4:0]             r_v;
    logic [3:0]             r_neg;

    logic [SAMPLE_BITS-1:0] w_src;
    logic [PROD_W-1:0]      w_prod;
    logic [QUANT_BITS-1:0]  w_q;
    logic [QUANT_BITS-1:0]  r_a_q;

    logic [DIV_W-1:0]       w_x;
    logic [DIV_W-1:0]       w_est;
    logic [DIV_W-1:0]       w_rem1;
    logic [DIV_W-1:0]       w_c;
    logic [DIV_W-1:0]       w_rem2;
    logic                   w_fix;
    logic [SAMPLE_BITS-1:0] r_b_y;

    logic [SQ_W-1:0]        r_c_sq;
    logic [SAMPLE_BITS-1:0] r_c_y;

    logic [SQ_W-1:0]        w_hi;
    logic [SQ_W-1:0]        w_lo;
    logic [SQ_W-1:0]        r_d_hi;
    logic [SQ_W-1:0]        r_d_lo;
    logic [SAMPLE_BITS-1:0] r_d_y;

    logic [RAD_W-1:0]       w_cube;
    logic [SAMPLE_BITS-1:0] w_yr;
    logic [OUT_BITS-1:0]    w_res;
    logic [OUT_BITS-1:0]    r_e_res;

    always_comb begin
        w_src  = i_cfg.power_en ? i_cell.y : i_cell.mag;
        w_prod = {w_src, {QUANT_BITS{1'b0}}} - PROD_W'(w_src);
        w_q    = w_prod[FRAC_BITS +: QUANT_BITS];
        if (i_cfg.xor_en) begin
            w_q = w_q ^ i_cfg.bit_mask;
        end
        if (i_cfg.and_en) begin
            w_q = w_q & i_cfg.bit_mask;
        end
    end

    // Division by 2^15-1 is done by folding the high part back onto the low part.
    always_comb begin
        w_x    = DIV_W'(r_a_q) << (FRAC_BITS - QUANT_BITS);
        w_est  = w_x >> QUANT_BITS;
        w_rem1 = DIV_W'(w_x[QUANT_BITS-1:0]) + w_est;
        w_c    = w_rem1 >> QUANT_BITS;
        w_rem2 = DIV_W'(w_rem1[QUANT_BITS-1:0]) + w_c;
        w_fix  = (w_rem2 >= DIV_W'(QUANT_MAX));
    end

    assign w_hi = r_c_sq[SQ_W-1:SAMPLE_BITS] * r_c_y;
    assign w_lo = r_c_sq[SAMPLE_BITS-1:0] * r_c_y;

    always_comb begin
        w_cube = {r_d_hi, {SAMPLE_BITS{1'b0}}} + RAD_W'(r_d_lo);
        w_yr   = i_cfg.power_en ? w_cube[2*FRAC_BITS +: SAMPLE_BITS] : r_d_y;
        w_res  = r_neg[3] ? (OUT_BITS'(0) - OUT_BITS'(w_yr)) : OUT_BITS'(w_yr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_cell.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg   <= {r_neg[2:0], i_cell.neg};
            r_a_q   <= w_q;
            r_b_y   <= SAMPLE_BITS'(w_x + w_est + w_c + DIV_W'(w_fix));
            r_c_sq  <= r_b_y * r_b_y;
            r_c_y   <= r_b_y;
            r_d_hi  <= w_hi;
            r_d_lo  <= w_lo;
            r_d_y   <= r_c_y;
            r_e_res <= w_res;
        end
    end

    assign o_valid  = r_v[4];
    assign o_sample = r_e_res;

endmodule

[rtl/sample_bit_mask_crusher.sv]
// Top level of the sample bit mask crusher: configuration registers, the cube
// root cell chain, the back end and the output register with its skid stage.
// Depends on bmc_pkg, bmc_if, bmc_root_chain and bmc_post.
//
// The block takes one signed sample per clock and returns one crushed sample per
// transfer, in order. From its input transfer to the earliest output transfer a
// sample passes the register that splits the sign, one cell per root bit in the
// cube root chain, five back end stages and the output register. The cube root
// chain sets the length; it runs in every mode so that the latency does not
// depend on the configuration. A result that is not taken waits in the output
// register while the next one is caught in a skid stage; input transfers stop
// only while that stage is full. Configuration writes are always taken and must
// only be made while no sample is in flight.
module sample_bit_mask_crusher import bmc_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    bmc_in_if.sink         i_smp,
    bmc_out_if.source      o_smp,
    bmc_cfg_if.sink        i_cfg
);

    t_cfg                r_cfg;
    t_cell               w_tail;
    logic                w_en;
    logic                w_pl_valid;
    logic [OUT_BITS-1:0] w_pl_sample;
    logic                w_out_xfer;
    logic                r_out_v;
    logic                n_out_v;
    logic [OUT_BITS-1:0] r_out_d;
    logic [OUT_BITS-1:0] n_out_d;
    logic                r_skid_v;
    logic                n_skid_v;
    logic [OUT_BITS-1:0] r_skid_d;
    logic [OUT_BITS-1:0] n_skid_d;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_mask <= QUANT_MAX;
            r_cfg.xor_en   <= 1'b0;
            r_cfg.and_en   <= 1'b0;
            r_cfg.power_en <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_BIT_MASK:     r_cfg.bit_mask <= i_cfg.data[QUANT_BITS-1:0];
                REG_XOR_ENABLE:   r_cfg.xor_en   <= i_cfg.data[0];
                REG_AND_ENABLE:   r_cfg.and_en   <= i_cfg.data[0];
                REG_POWER_ENABLE: r_cfg.power_en <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    assign w_en        = !r_skid_v;
    assign i_smp.ready = w_en;

    bmc_root_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_smp.valid),
        .i_sample(i_smp.in_sample),
        .o_cell  (w_tail)
    );

    bmc_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (r_cfg),
        .i_cell  (w_tail),
        .o_valid (w_pl_valid),
        .o_sample(w_pl_sample)
    );

    assign w_out_xfer = r_out_v && o_smp.ready;

    always_comb begin
        n_out_v  = r_out_v;
        n_out_d  = r_out_d;
        n_skid_v = r_skid_v;
        n_skid_d = r_skid_d;
        if (w_out_xfer) begin
            n_out_v = 1'b0;
        end
        if (r_skid_v) begin
            if (!n_out_v) begin
                n_out_v  = 1'b1;
                n_out_d  = r_skid_d;
                n_skid_v = 1'b0;
            end
        end else if (w_pl_valid) begin
            if (!n_out_v) begin
                n_out_v = 1'b1;
                n_out_d = w_pl_sample;
            end else begin
                n_skid_v = 1'b1;
                n_skid_d = w_pl_sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_d  <= n_out_d;
        r_skid_d <= n_skid_d;
    end

    assign o_smp.valid      = r_out_v;
    assign o_smp.out_sample = r_out_d;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid stage holds a result while the output register is empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !$past(r_skid_v)) |-> $past(r_out_v && !o_smp.ready))
        else $error("skid stage filled while the output was not stalled");

    a_mag_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_smp.valid |->
            (!o_smp.out_sample[OUT_BITS-1] &&
             (!o_smp.out_sample[FRAC_BITS] || o_smp.out_sample[FRAC_BITS-1:0] == '0)) ||
            (o_smp.out_sample[OUT_BITS-1] && o_smp.out_sample[FRAC_BITS]))
        else $error("output magnitude exceeds one");

    a_zero_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_smp.valid && r_cfg.and_en && r_cfg.bit_mask == '0) |-> o_smp.out_sample == '0)
        else $error("nonzero output with an all-zero AND mask");

endmodule

[bench/tb_sample_bit_mask_crusher.sv]
`timescale 1ns / 1ps
// Self-checking testbench for sample_bit_mask_crusher: drives samples and register writes,
// predicts every crushed sample in exact integer arithmetic and compares in order.
// Depends on bmc_pkg, the bmc_if interfaces and the crusher RTL.
module tb_sample_bit_mask_crusher;
    import bmc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int LONG_HOLD      = 300;
    localparam int HOLD_AT_COUNT  = 500;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(255);
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {FRAC_BITS{1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {FRAC_BITS{1'b0}}};

    logic i_clk = 1'b0;
    logic i_rst_n;

    bmc_in_if  smp_in ();
    bmc_out_if smp_out ();
    bmc_cfg_if cfg ();

    sample_bit_mask_crusher dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_in),
        .o_smp   (smp_out),
        .i_cfg   (cfg)
    );

    always #5 i_clk = ~i_clk;

    logic signed [SAMPLE_BITS-1:0] samples_to_send[$];
    logic signed [OUT_BITS-1:0]    crushed_expected[$];

    logic [QUANT_BITS-1:0] mask_q  = QUANT_MAX;
    logic                  xor_q   = 1'b0;
    logic                  and_q   = 1'b0;
    logic                  power_q = 1'b0;

    logic smp_fire = 1'b0;
    logic idling_on = 1'b1;
    int   samples_accepted = 0;
    int   errors = 0;
    int   idle_cycles = 0;
    int   src_gap = 0;
    int   sink_gap = 0;
    int   hold_cnt = 0;
    bit   held_once = 1'b0;

    function automatic logic signed [OUT_BITS-1:0] crush_sample(
        input logic signed [SAMPLE_BITS-1:0] smp);
        logic                  neg;
        logic [SAMPLE_BITS-1:0] mag;
        logic [SAMPLE_BITS-1:0] lo;
        logic [SAMPLE_BITS-1:0] hi;
        logic [SAMPLE_BITS-1:0] mid;
        logic [RAD_W-1:0]       target;
        logic [RAD_W-1:0]       cube;
        logic [PROD_W-1:0]      prod;
        logic [QUANT_BITS-1:0]  q;
        logic [PROD_W-1:0]      num;
        logic [SAMPLE_BITS-1:0] y;
        neg = smp[SAMPLE_BITS-1];
        mag = neg ? SAMPLE_BITS'(0) - SAMPLE_BITS'(smp) : SAMPLE_BITS'(smp);
        if (power_q) begin
            target = RAD_W'(mag) << (2 * FRAC_BITS);
            lo = '0;
            hi = SAMPLE_BITS'(1) << FRAC_BITS;
            while (lo < hi) begin
                mid = lo + ((hi - lo + SAMPLE_BITS'(1)) >> 1);
                cube = RAD_W'(mid) * RAD_W'(mid) * RAD_W'(mid);
                if (cube <= target) lo = mid;
                else hi = mid - SAMPLE_BITS'(1);
            end
            mag = lo;
        end
        prod = PROD_W'(mag) * PROD_W'(QUANT_MAX);
        q = QUANT_BITS'(prod >> FRAC_BITS);
        if (xor_q) q = q ^ mask_q;
        if (and_q) q = q & mask_q;
        num = PROD_W'(q) << FRAC_BITS;
        y = SAMPLE_BITS'(num / PROD_W'(QUANT_MAX));
        if (power_q) begin
            cube = RAD_W'(y) * RAD_W'(y) * RAD_W'(y);
            y = SAMPLE_BITS'(cube >> (2 * FRAC_BITS));
        end
        return neg ? OUT_BITS'(0) - OUT_BITS'(y) : OUT_BITS'(y);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: return SMP_MIN;
                    1: return SMP_MAX;
                    2: return '0;
                    3: return '1;
                    default: return SAMPLE_BITS'(1);
                endcase
            end
            1, 2: return SAMPLE_BITS'($urandom_range(0, 2047)) - SAMPLE_BITS'(1024);
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic signed [OUT_BITS-1:0] got,
                                   input logic signed [OUT_BITS-1:0] want);
        if (errors < 50)
            $display("ERROR at %0t ns: %s, got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge i_clk); while (!cfg.ready);
        case (idx)
            REG_BIT_MASK:     mask_q  = val;
            REG_XOR_ENABLE:   xor_q   = val[0];
            REG_AND_ENABLE:   and_q   = val[0];
            REG_POWER_ENABLE: power_q = val[0];
            default: begin
            end
        endcase
        @(negedge i_clk);
        cfg.valid <= 1'b0;
    endtask

    // Enable registers get random upper data bits, which the block must ignore.
    task automatic program_crusher(input logic [QUANT_BITS-1:0] mask, input logic x_en,
                                   input logic a_en, input logic p_en);
        write_reg(REG_BIT_MASK, mask);
        write_reg(REG_XOR_ENABLE, {14'($urandom()), x_en});
        write_reg(REG_AND_ENABLE, {14'($urandom()), a_en});
        write_reg(REG_POWER_ENABLE, {14'($urandom()), p_en});
    endtask

    task automatic wait_flushed();
        while (samples_to_send.size() != 0 || crushed_expected.size() != 0 || smp_in.valid)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic queue_random(input int count);
        repeat (count) samples_to_send.push_back(pick_sample());
    endtask

    always @(negedge i_clk) begin
        if (smp_fire)
            void'(samples_to_send.pop_front());
        if (!i_rst_n) begin
            smp_in.valid <= 1'b0;
        end else if (smp_in.valid && !smp_fire) begin
        end else if (src_gap > 0) begin
            src_gap--;
            smp_in.valid <= 1'b0;
        end else if (idling_on && $urandom_range(0, 7) == 0) begin
            src_gap = $urandom_range(0, 14);
            smp_in.valid <= 1'b0;
        end else if (samples_to_send.size() != 0) begin
            smp_in.valid     <= 1'b1;
            smp_in.in_sample <= samples_to_send[0];
        end else begin
            smp_in.valid <= 1'b0;
        end
    end

    // The long hold lets the block fill up while the sender keeps offering samples.
    always @(negedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt--;
            smp_out.ready <= 1'b0;
        end else if (!held_once && samples_accepted >= HOLD_AT_COUNT) begin
            held_once = 1'b1;
            hold_cnt  = LONG_HOLD;
            smp_out.ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            smp_out.ready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 9) == 0) begin
            sink_gap = $urandom_range(0, 14);
            smp_out.ready <= 1'b0;
        end else begin
            smp_out.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        smp_fire <= i_rst_n && smp_in.valid && smp_in.ready;
        if (i_rst_n && smp_in.valid && smp_in.ready) begin
            crushed_expected.push_back(crush_sample(smp_in.in_sample));
            samples_accepted <= samples_accepted + 1;
        end
        if (i_rst_n && smp_out.valid && smp_out.ready) begin
            if (crushed_expected.size() == 0)
                report_mismatch("result with nothing pending", smp_out.out_sample, '0);
            else if (smp_out.out_sample !== crushed_expected[0])
                report_mismatch("out_sample", smp_out.out_sample, crushed_expected.pop_front());
            else
                void'(crushed_expected.pop_front());
        end
    end

    always @(posedge i_clk) begin
        if ((smp_in.valid && smp_in.ready) || (smp_out.valid && smp_out.ready)
                || (cfg.valid && cfg.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        cfg.valid        = 1'b0;
        cfg.index        = '0;
        cfg.data         = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed samples under the reset settings.
        samples_to_send.push_back('0);
        samples_to_send.push_back(SAMPLE_BITS'(1));
        samples_to_send.push_back('1);
        samples_to_send.push_back(SMP_MAX);
        samples_to_send.push_back(SMP_MIN);
        samples_to_send.push_back(SMP_MIN + SAMPLE_BITS'(1));
        samples_to_send.push_back(SAMPLE_BITS'(24'h400000));
        samples_to_send.push_back(SAMPLE_BITS'(24'hc00000));
        samples_to_send.push_back(SAMPLE_BITS'(255));
        samples_to_send.push_back(SAMPLE_BITS'(256));
        samples_to_send.push_back(SAMPLE_BITS'(257));
        samples_to_send.push_back(-SAMPLE_BITS'(200));
        samples_to_send.push_back(SAMPLE_BITS'(24'h555555));
        samples_to_send.push_back(SAMPLE_BITS'(24'haaaaaa));
        samples_to_send.push_back(SAMPLE_BITS'(24'h000100));
        samples_to_send.push_back(SAMPLE_BITS'(24'h7fff00));
        wait_flushed();

        write_reg(REG_UNUSED, 15'($urandom()));
        program_crusher('0, 1'b0, 1'b1, 1'b0);
        queue_random(100);
        wait_flushed();

        program_crusher(QUANT_MAX, 1'b1, 1'b0, 1'b0);
        queue_random(100);
        wait_flushed();

        program_crusher(QUANT_MAX, 1'b1, 1'b1, 1'b1);
        queue_random(100);
        wait_flushed();

        program_crusher('0, 1'b0, 1'b0, 1'b1);
        queue_random(100);
        wait_flushed();

        for (int ph = 0; ph < 6; ph++) begin
            program_crusher(15'($urandom()), 1'($urandom()), 1'($urandom()), 1'($urandom()));
            queue_random(60);
            if (ph == 2)
                wait_flushed();
            queue_random(60);
            wait_flushed();
        end

        idling_on = 1'b0;
        program_crusher(15'($urandom()), 1'b1, 1'b1, 1'($urandom()));
        queue_random(100);
        wait_flushed();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[files.f]
rtl/bmc_pkg.sv
rtl/bmc_if.sv
rtl/bmc_root_cell.sv
rtl/bmc_root_chain.sv
rtl/bmc_post.sv
rtl/sample_bit_mask_crusher.sv
bench/tb_sample_bit_mask_crusher.sv
